### rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   // Per-cycle operation broadcast to every cell of the chain.
   typedef struct packed {
      logic ins_en;
      logic rem_en;
   } ctrl_type;

endpackage

### rtl/core/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; #(
   parameter int KEY_BITS = 6,
   parameter int TAG_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_type            ctrl,
   input  logic [KEY_BITS-1:0] new_key,
   input  logic [TAG_BITS-1:0] new_tag,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic [TAG_BITS-1:0] left_tag,
   input  logic                left_used,
   input  logic                left_bump,
   input  logic [KEY_BITS-1:0] right_key,
   input  logic [TAG_BITS-1:0] right_tag,
   input  logic                right_used,
   output logic [KEY_BITS-1:0] key,
   output logic [TAG_BITS-1:0] tag,
   output logic                used,
   output logic                bump
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic                used_ff, used_in;

   // Cell is at or past the insert point: empty, or holds a strictly larger key.
   assign bump = !used_ff || (key_ff > new_key);

   always_comb begin
      key_in  = key_ff;
      tag_in  = tag_ff;
      used_in = used_ff;
      priority if (ctrl.ins_en) begin
         priority if (left_bump) begin
            key_in = left_key;
            tag_in = left_tag;
         end else if (bump) begin
            key_in = new_key;
            tag_in = new_tag;
         end else begin
            key_in = key_ff;
            tag_in = tag_ff;
         end
         used_in = used_ff | left_used;
      end else if (ctrl.rem_en) begin
         key_in  = right_key;
         tag_in  = right_tag;
         used_in = right_used;
      end else begin
         used_in = used_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign key  = key_ff;
   assign tag  = tag_ff;
   assign used = used_ff;

endmodule

### rtl/core/stable_sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// Stable sorted priority queue, QUEUE_DEPTH entries of (key, tag).
// Request channel (req_*): command 0 inserts entry_key/entry_tag behind every
// held entry with a key less than or equal to it; command 1 pops the head,
// the entry with the smallest key. Equal keys leave in arrival order.
// Response channel (rsp_*): exactly one response per request, in order. A pop
// returns the head with out_valid set, or was_empty when nothing is held; an
// insert into a full queue is dropped with overflow set. fill_count is the
// number of entries held after the request.
// Storage is a chain of cells; on each transfer every cell compares its key
// with the new one and takes its left neighbor, the new entry, its right
// neighbor or holds.
// Latency: response is valid the cycle after the request transfer.
// Throughput: one request per cycle while rsp_ready is high; a stalled
// response holds in the output register and req_ready drops until it leaves.
// Reset empties the queue at once and drops any pending response.
module stable_sorted_priority_queue_unit import spq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int KEY_BITS    = 6,
   parameter int TAG_BITS    = 8,
   localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [KEY_BITS-1:0] req_entry_key,
   input  logic [TAG_BITS-1:0] req_entry_tag,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_out_valid,
   output logic [KEY_BITS-1:0] rsp_out_key,
   output logic [TAG_BITS-1:0] rsp_out_tag,
   output logic                rsp_was_empty,
   output logic                rsp_overflow,
   output logic [CNT_BITS-1:0] rsp_fill_count
);

   logic [KEY_BITS-1:0] cell_key  [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] cell_tag  [QUEUE_DEPTH];
   logic                cell_used [QUEUE_DEPTH];
   logic                cell_bump [QUEUE_DEPTH];

   logic [KEY_BITS-1:0] lk [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] lt [QUEUE_DEPTH];
   logic                lu [QUEUE_DEPTH];
   logic                lb [QUEUE_DEPTH];
   logic [KEY_BITS-1:0] rk [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] rt [QUEUE_DEPTH];
   logic                ru [QUEUE_DEPTH];

   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic [KEY_BITS-1:0] out_key_ff, out_key_in;
   logic [TAG_BITS-1:0] out_tag_ff, out_tag_in;
   logic                was_empty_ff, was_empty_in;
   logic                overflow_ff, overflow_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] fill_ff, fill_in;

   logic     xfer;
   logic     is_full;
   logic     is_empty;
   cmd_type  cmd;
   ctrl_type ctrl;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign xfer      = req_valid && req_ready;
   assign cmd       = cmd_type'(req_command);
   assign is_full   = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign is_empty  = !cell_used[0];

   assign ctrl.ins_en = xfer && (cmd == CMD_INSERT) && !is_full;
   assign ctrl.rem_en = xfer && (cmd == CMD_REMOVE) && !is_empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         // Head sees a used, never-bumping neighbor on its left.
         assign lk[i] = '0;
         assign lt[i] = '0;
         assign lu[i] = 1'b1;
         assign lb[i] = 1'b0;
      end else begin : g_mid
         assign lk[i] = cell_key[i-1];
         assign lt[i] = cell_tag[i-1];
         assign lu[i] = cell_used[i-1];
         assign lb[i] = cell_bump[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign rk[i] = '0;
         assign rt[i] = '0;
         assign ru[i] = 1'b0;
      end else begin : g_body
         assign rk[i] = cell_key[i+1];
         assign rt[i] = cell_tag[i+1];
         assign ru[i] = cell_used[i+1];
      end

      spq_cell #(
         .KEY_BITS (KEY_BITS),
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_key    (req_entry_key),
         .new_tag    (req_entry_tag),
         .left_key   (lk[i]),
         .left_tag   (lt[i]),
         .left_used  (lu[i]),
         .left_bump  (lb[i]),
         .right_key  (rk[i]),
         .right_tag  (rt[i]),
         .right_used (ru[i]),
         .key        (cell_key[i]),
         .tag        (cell_tag[i]),
         .used       (cell_used[i]),
         .bump       (cell_bump[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_valid_in = out_valid_ff;
      out_key_in   = out_key_ff;
      out_tag_in   = out_tag_ff;
      was_empty_in = was_empty_ff;
      overflow_in  = overflow_ff;
      count_in     = count_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (xfer) begin
         rsp_valid_in = 1'b1;
         out_valid_in = ctrl.rem_en;
         out_key_in   = ctrl.rem_en ? cell_key[0] : '0;
         out_tag_in   = ctrl.rem_en ? cell_tag[0] : '0;
         was_empty_in = (cmd == CMD_REMOVE) && is_empty;
         overflow_in  = (cmd == CMD_INSERT) && is_full;
         priority if (ctrl.ins_en) begin
            count_in = count_ff + CNT_BITS'(1);
         end else if (ctrl.rem_en) begin
            count_in = count_ff - CNT_BITS'(1);
         end else begin
            count_in = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      out_valid_ff <= out_valid_in;
      out_key_ff   <= out_key_in;
      out_tag_ff   <= out_tag_in;
      was_empty_ff <= was_empty_in;
      overflow_ff  <= overflow_in;
   end

   // Fill count captured alongside the response payload.
   assign fill_in = xfer ? count_in : fill_ff;

   always_ff @(posedge clock) begin
      fill_ff <= fill_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_valid  = out_valid_ff;
   assign rsp_out_key    = out_key_ff;
   assign rsp_out_tag    = out_tag_ff;
   assign rsp_was_empty  = was_empty_ff;
   assign rsp_overflow   = overflow_ff;
   assign rsp_fill_count = fill_ff;

endmodule

### rtl/core/spq_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spq_checker #(
   parameter int QUEUE_DEPTH = 16,
   parameter int KEY_BITS    = 6,
   parameter int TAG_BITS    = 8,
   parameter int CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_out_valid,
   input logic [KEY_BITS-1:0] rsp_out_key,
   input logic [TAG_BITS-1:0] rsp_out_tag,
   input logic                rsp_was_empty,
   input logic                rsp_overflow,
   input logic [CNT_BITS-1:0] rsp_fill_count
);

   logic rsp_busy;
   logic flags_ok;
   logic miss_zero;
   logic pop_seen;
   logic miss_seen;
   logic ovf_seen;
   logic empty_seen;
   logic full_cnt;
   logic zero_cnt;
   logic [KEY_BITS+TAG_BITS+CNT_BITS+2:0] rsp_payload;

   assign rsp_busy    = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_out_valid, rsp_out_key, rsp_out_tag, rsp_was_empty,
                         rsp_overflow, rsp_fill_count};
   assign flags_ok    = !rsp_was_empty && !rsp_overflow;
   assign miss_zero   = (rsp_out_key == '0) && (rsp_out_tag == '0);
   assign pop_seen    = rsp_valid && rsp_out_valid;
   assign miss_seen   = rsp_valid && !rsp_out_valid;
   assign ovf_seen    = rsp_valid && rsp_overflow;
   assign empty_seen  = rsp_valid && rsp_was_empty;
   assign full_cnt    = (rsp_fill_count == CNT_BITS'(QUEUE_DEPTH));
   assign zero_cnt    = (rsp_fill_count == '0);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_busy, rsp_valid && $stable(rsp_payload), "stalled response changed")
   `ASSERT_IMPLIES(a_pop_flags, clock, reset, pop_seen, flags_ok, "pop with error flag")
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, miss_seen, miss_zero, "nonzero entry without pop")
   `ASSERT_IMPLIES(a_ovf_full, clock, reset, ovf_seen, full_cnt, "overflow while not full")
   `ASSERT_IMPLIES(a_empty_cnt, clock, reset, empty_seen, zero_cnt, "empty flag with entries held")

endmodule

bind stable_sorted_priority_queue_unit spq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH),
   .KEY_BITS    (KEY_BITS),
   .TAG_BITS    (TAG_BITS)
) u_spq_checker (.*);

### test/tb_stable_sorted_priority_queue_unit.sv
`timescale 1ns / 1ps

module tb_stable_sorted_priority_queue_unit;
   import spq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int KEY_W       = 6;
   localparam int TAG_W       = 8;
   localparam int CNT_W       = 5;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int HOLD_CYCLES = 64;
   localparam int STALL_LIMIT = 3000;

   typedef struct packed {
      logic             out_valid;
      logic [KEY_W-1:0] out_key;
      logic [TAG_W-1:0] out_tag;
      logic             was_empty;
      logic             overflow;
      logic [CNT_W-1:0] fill_count;
   } queue_result_t;

   typedef struct packed {
      cmd_type          cmd;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             typed;
      queue_result_t    result;
   } stim_row_t;

   localparam queue_result_t NOT_TYPED    = '0;
   localparam queue_result_t EMPTY_POP    = '{1'b0, 6'd0, 8'd0, 1'b1, 1'b0, 5'd0};
   localparam queue_result_t FIRST_INSERT = '{1'b0, 6'd0, 8'd0, 1'b0, 1'b0, 5'd1};
   localparam queue_result_t FULL_DROP    = '{1'b0, 6'd0, 8'd0, 1'b0, 1'b1, 5'd16};

   // pop on empty, extremes of key/tag, equal keys kept in order, fill to full, drop
   localparam stim_row_t DIRECTED_ROWS [0:22] = '{
      '{CMD_REMOVE, 6'd0,  8'd0,   1'b1, EMPTY_POP},
      '{CMD_INSERT, 6'd63, 8'd255, 1'b1, FIRST_INSERT},
      '{CMD_INSERT, 6'd0,  8'd0,   1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd0,  8'd170, 1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd63, 8'd85,  1'b0, NOT_TYPED},
      '{CMD_REMOVE, 6'd63, 8'd255, 1'b0, NOT_TYPED},
      '{CMD_REMOVE, 6'd21, 8'd85,  1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd42, 8'd170, 1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd21, 8'd85,  1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd42, 8'd15,  1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd1,  8'd240, 1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd63, 8'd0,   1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd0,  8'd204, 1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd32, 8'd51,  1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd21, 8'd1,   1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd5,  8'd128, 1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd10, 8'd64,  1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd62, 8'd2,   1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd42, 8'd99,  1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd0,  8'd7,   1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd33, 8'd254, 1'b0, NOT_TYPED},
      '{CMD_INSERT, 6'd7,  8'd77,  1'b1, FULL_DROP},
      '{CMD_REMOVE, 6'd0,  8'd0,   1'b0, NOT_TYPED}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_command = 1'b0;
   logic [KEY_W-1:0] req_entry_key = '0;
   logic [TAG_W-1:0] req_entry_tag = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_out_valid;
   logic [KEY_W-1:0] rsp_out_key;
   logic [TAG_W-1:0] rsp_out_tag;
   logic             rsp_was_empty;
   logic             rsp_overflow;
   logic [CNT_W-1:0] rsp_fill_count;

   // typed expectation travels with the payload, sampled at the transfer
   logic             item_typed = 1'b0;
   queue_result_t    item_result = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request  = 1'b0;
   int mismatches    = 0;
   int idle_cycles   = 0;
   int n_inserts     = 0;
   int n_pops        = 0;
   int n_drops       = 0;
   int n_empty_pops  = 0;

   logic [KEY_W-1:0] shadow_key [DEPTH];
   logic [TAG_W-1:0] shadow_tag [DEPTH];
   int               shadow_count = 0;
   queue_result_t    pending_results [$];

   stable_sorted_priority_queue_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_entry_key  (req_entry_key),
      .req_entry_tag  (req_entry_tag),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_out_key    (rsp_out_key),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_was_empty  (rsp_was_empty),
      .rsp_overflow   (rsp_overflow),
      .rsp_fill_count (rsp_fill_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // sorted insert behind equal keys, pop from head
   function automatic queue_result_t apply_to_shadow(cmd_type cmd, logic [KEY_W-1:0] key,
                                                     logic [TAG_W-1:0] tag);
      queue_result_t r;
      int pos;
      int i;
      r = '0;
      if (cmd == CMD_INSERT) begin
         if (shadow_count >= DEPTH) begin
            r.overflow = 1'b1;
         end else begin
            pos = 0;
            while (pos < shadow_count && shadow_key[pos] <= key) pos++;
            for (i = shadow_count; i > pos; i--) begin
               shadow_key[i] = shadow_key[i-1];
               shadow_tag[i] = shadow_tag[i-1];
            end
            shadow_key[pos] = key;
            shadow_tag[pos] = tag;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            r.was_empty = 1'b1;
         end else begin
            r.out_valid = 1'b1;
            r.out_key   = shadow_key[0];
            r.out_tag   = shadow_tag[0];
            for (i = 0; i + 1 < shadow_count; i++) begin
               shadow_key[i] = shadow_key[i+1];
               shadow_tag[i] = shadow_tag[i+1];
            end
            shadow_count--;
         end
      end
      r.fill_count = shadow_count[CNT_W-1:0];
      return r;
   endfunction

   task automatic compare_field(string name, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
      if (got !== want) begin
         $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      queue_result_t predicted;
      queue_result_t want;
      if (!reset && req_valid && req_ready) begin
         predicted = apply_to_shadow(cmd_type'(req_command), req_entry_key, req_entry_tag);
         if (predicted.overflow) n_drops++;
         else if (predicted.was_empty) n_empty_pops++;
         else if (predicted.out_valid) n_pops++;
         else n_inserts++;
         pending_results.push_back(item_typed ? item_result : predicted);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response transfer with nothing pending", $time);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            compare_field("out_valid",  TAG_W'(want.out_valid),  TAG_W'(rsp_out_valid));
            compare_field("out_key",    TAG_W'(want.out_key),    TAG_W'(rsp_out_key));
            compare_field("out_tag",    want.out_tag,            rsp_out_tag);
            compare_field("was_empty",  TAG_W'(want.was_empty),  TAG_W'(rsp_was_empty));
            compare_field("overflow",   TAG_W'(want.overflow),   TAG_W'(rsp_overflow));
            compare_field("fill_count", TAG_W'(want.fill_count), TAG_W'(rsp_fill_count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(cmd_type cmd, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                            logic typed, queue_result_t result);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_entry_key <= key;
      req_entry_tag <= tag;
      item_typed    <= typed;
      item_result   <= result;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // bursts lean toward inserts or pops so the queue swings between full and empty;
   // narrow key ranges give many equal keys
   task automatic send_random(int count);
      int insert_pct;
      bit narrow_keys;
      cmd_type cmd;
      logic [KEY_W-1:0] key;
      int n;
      insert_pct  = 50;
      narrow_keys = 1'b0;
      for (n = 0; n < count; n++) begin
         if (n % 24 == 0) begin
            case ($urandom_range(2))
               0: insert_pct = 85;
               1: insert_pct = 50;
               default: insert_pct = 15;
            endcase
            narrow_keys = ($urandom_range(1) == 1);
         end
         cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
         key = narrow_keys ? KEY_W'($urandom_range(3)) : KEY_W'($urandom_range(63));
         send_item(cmd, key, TAG_W'($urandom_range(255)), 1'b0, NOT_TYPED);
      end
   endtask

   initial begin
      int r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 19;
      recv_idle_pct = 87;
      for (r = 0; r < $size(DIRECTED_ROWS); r++) begin
         send_item(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].tag,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);
      end
      send_random(ITEMS_PER_PHASE);

      send_idle_pct = 87;
      recv_idle_pct = 19;
      send_random(ITEMS_PER_PHASE);

      // long receiver stall while the sender keeps pushing
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      send_random(ITEMS_PER_PHASE);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("covered %0d inserts, %0d pops, %0d drops on full, %0d pops on empty",
               n_inserts, n_pops, n_drops, n_empty_pops);
      $display("three back-pressure mixes and a %0d-cycle receiver stall", HOLD_CYCLES);
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
